@@ hdl/rfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and the CRC-8 byte update for the reply frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam logic [7:0] SYNC_RESET    = 8'hAA;
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;   // 0x31 reflected
  localparam logic [7:0] TYPE_STATUS   = 8'h04;

  localparam logic [3:0] LEN_SHORT = 4'd5;
  localparam logic [3:0] LEN_LONG  = 4'd11;
  localparam logic [3:0] LEN_NONE  = 4'd0;

  localparam int unsigned NUM_STATUS = 6;

  // byte position within the frame, also the hunt/collect phase
  localparam logic [3:0] CNT_HUNT        = 4'd0;
  localparam logic [3:0] CNT_BOARD       = 4'd1;
  localparam logic [3:0] CNT_TYPE        = 4'd2;
  localparam logic [3:0] CNT_ARG         = 4'd3;
  localparam logic [3:0] CNT_STATUS0     = 4'd4;
  localparam logic [3:0] CNT_SHORT_CHECK = 4'd4;
  localparam logic [3:0] CNT_LONG_CHECK  = 4'd10;

  typedef enum logic [1:0] {
    RES_GOOD     = 2'd0,
    RES_BAD_TYPE = 2'd1,
    RES_BAD_CRC  = 2'd2
  } rfc_code_t;

  typedef struct packed {
    rfc_code_t                       code;
    logic [7:0]                      board_addr;
    logic [7:0]                      msg_type;
    logic [7:0]                      arg_value;
    logic [NUM_STATUS-1:0][7:0]      status;
    logic [3:0]                      frame_length;
  } rfc_result_t;

  // one byte of reflected CRC-8, eight bit steps unrolled
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/rfc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_in_if
// Received byte channel: valid/ready with one serial byte.
// ----------------------------------------------------------------------------
interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/rfc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_out_if
// Frame result channel: valid/ready with the decoded frame fields.
// ----------------------------------------------------------------------------
interface rfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_code;
  logic [7:0] board_addr;
  logic [7:0] msg_type;
  logic [7:0] arg_value;
  logic [7:0] status_b0;
  logic [7:0] status_b1;
  logic [7:0] status_b2;
  logic [7:0] status_b3;
  logic [7:0] status_b4;
  logic [7:0] status_b5;
  logic [3:0] frame_length;

  modport source (
    output valid, input ready,
    output result_code, output board_addr, output msg_type, output arg_value,
    output status_b0, output status_b1, output status_b2, output status_b3,
    output status_b4, output status_b5, output frame_length
  );
  modport sink (
    input valid, output ready,
    input result_code, input board_addr, input msg_type, input arg_value,
    input status_b0, input status_b1, input status_b2, input status_b3,
    input status_b4, input status_b5, input frame_length
  );
endinterface

@@ hdl/rfc_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_deframer
// Frame state and CRC accumulator; consumes one byte per step and flags a
// result on the step that closes or rejects a frame.
// ----------------------------------------------------------------------------
module rfc_deframer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           sync_value,
  output logic                 res_valid,
  output rfc_pkg::rfc_result_t res
);

  logic [3:0] cnt_r,   cnt_nxt;
  logic       long_r,  long_nxt;
  logic [7:0] crc_r,   crc_nxt;
  logic [7:0] board_r, board_nxt;
  logic [7:0] type_r,  type_nxt;
  logic [7:0] arg_r,   arg_nxt;
  logic [7:0] status_r [rfc_pkg::NUM_STATUS];

  logic       stat_we;
  logic [2:0] stat_idx;
  logic [7:0] crc_step;

  // the first byte of a frame always starts from a zero crc
  assign crc_step = rfc_pkg::crc8_update((cnt_r == rfc_pkg::CNT_HUNT) ? 8'h00 : crc_r,
                                         rx_byte);
  assign stat_idx = 3'(cnt_r - rfc_pkg::CNT_STATUS0);

  always_comb begin
    cnt_nxt   = cnt_r;
    long_nxt  = long_r;
    crc_nxt   = crc_r;
    board_nxt = board_r;
    type_nxt  = type_r;
    arg_nxt   = arg_r;
    stat_we   = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    case (cnt_r)
      rfc_pkg::CNT_HUNT: begin
        if (rx_byte == sync_value) begin
          crc_nxt = crc_step;
          cnt_nxt = rfc_pkg::CNT_BOARD;
        end
      end
      rfc_pkg::CNT_BOARD: begin
        board_nxt = rx_byte;
        crc_nxt   = crc_step;
        cnt_nxt   = rfc_pkg::CNT_TYPE;
      end
      rfc_pkg::CNT_TYPE: begin
        type_nxt = rx_byte;
        if (rx_byte inside {8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd6}) begin
          long_nxt = 1'b0;
          crc_nxt  = crc_step;
          cnt_nxt  = rfc_pkg::CNT_ARG;
        end else if (rx_byte == rfc_pkg::TYPE_STATUS) begin
          long_nxt = 1'b1;
          crc_nxt  = crc_step;
          cnt_nxt  = rfc_pkg::CNT_ARG;
        end else begin
          res_valid        = 1'b1;
          res.code         = rfc_pkg::RES_BAD_TYPE;
          res.board_addr   = board_r;
          res.msg_type     = rx_byte;
          res.frame_length = rfc_pkg::LEN_NONE;
          long_nxt         = 1'b0;
          cnt_nxt          = rfc_pkg::CNT_HUNT;
        end
      end
      rfc_pkg::CNT_ARG: begin
        arg_nxt = rx_byte;
        crc_nxt = crc_step;
        cnt_nxt = rfc_pkg::CNT_STATUS0;
      end
      default: begin
        if (long_r && (cnt_r < rfc_pkg::CNT_LONG_CHECK)) begin
          stat_we = 1'b1;
          crc_nxt = crc_step;
          cnt_nxt = cnt_r + 4'd1;
        end else begin
          // check byte
          res_valid      = 1'b1;
          res.code       = (rx_byte == crc_r) ? rfc_pkg::RES_GOOD : rfc_pkg::RES_BAD_CRC;
          res.board_addr = board_r;
          res.msg_type   = type_r;
          res.arg_value  = arg_r;
          for (int i = 0; i < rfc_pkg::NUM_STATUS; i++) begin
            res.status[i] = long_r ? status_r[i] : 8'h00;
          end
          res.frame_length = long_r ? rfc_pkg::LEN_LONG : rfc_pkg::LEN_SHORT;
          long_nxt         = 1'b0;
          cnt_nxt          = rfc_pkg::CNT_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= rfc_pkg::CNT_HUNT;
      long_r  <= 1'b0;
      crc_r   <= 8'h00;
      board_r <= 8'h00;
      type_r  <= 8'h00;
      arg_r   <= 8'h00;
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      long_r  <= long_nxt;
      crc_r   <= crc_nxt;
      board_r <= board_nxt;
      type_r  <= type_nxt;
      arg_r   <= arg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && stat_we) begin
      status_r[stat_idx] <= rx_byte;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rfc_pkg::CNT_LONG_CHECK)
    else $error("byte count beyond status frame length");

  a_short_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!long_r && cnt_r > rfc_pkg::CNT_ARG) |-> cnt_r == rfc_pkg::CNT_SHORT_CHECK)
    else $error("short frame entered status bytes");

  a_result_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid) |=> (cnt_r == rfc_pkg::CNT_HUNT && !long_r))
    else $error("no return to hunt after a result");

  a_hunt_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == rfc_pkg::CNT_HUNT) |-> !res_valid)
    else $error("result raised while hunting");

endmodule

@@ hdl/reply_frame_checker_crc8.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reply_frame_checker_crc8
// Pulls sync-framed reply frames out of a serial byte stream and checks their
// CRC-8 (Dallas/Maxim).
// ----------------------------------------------------------------------------
// Takes one received byte per clock while the output register is free. A byte
// goes into an input register before the frame logic consumes it; any result it
// closes goes straight into the output register, so the check byte (or bad type
// byte) passes the input register and its result the output register. The CRC-8
// update is fully unrolled, so the sustained rate is one byte per clock
// whenever the result side takes its transactions. Results: code 0 good frame,
// 1 unknown message type, 2 CRC mismatch; after any frame the block hunts for
// the next sync byte (cfg register, reset 0xAA).
module reply_frame_checker_crc8 (
  input  logic       clk,
  input  logic       rst_n,
  rfc_in_if.sink     in_if,
  rfc_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [7:0]           sync_r;
  logic [7:0]           in_byte_r;
  logic                 in_vld_r;
  logic                 out_vld_r;
  rfc_pkg::rfc_result_t res_r;

  logic                 out_free;
  logic                 s1_fire;
  logic                 res_valid;
  rfc_pkg::rfc_result_t res;

  assign out_free    = !out_vld_r || out_if.ready;
  assign s1_fire     = in_vld_r && out_free;
  assign in_if.ready = !in_vld_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= rfc_pkg::SYNC_RESET;
    end else if (cfg_we) begin
      sync_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_vld_r <= 1'b1;
    end else if (s1_fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.rx_byte;
    end
  end

  rfc_deframer u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_fire),
    .rx_byte    (in_byte_r),
    .sync_value (sync_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      res_r <= res;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.result_code  = res_r.code;
  assign out_if.board_addr   = res_r.board_addr;
  assign out_if.msg_type     = res_r.msg_type;
  assign out_if.arg_value    = res_r.arg_value;
  assign out_if.status_b0    = res_r.status[0];
  assign out_if.status_b1    = res_r.status[1];
  assign out_if.status_b2    = res_r.status[2];
  assign out_if.status_b3    = res_r.status[3];
  assign out_if.status_b4    = res_r.status[4];
  assign out_if.status_b5    = res_r.status[5];
  assign out_if.frame_length = res_r.frame_length;

endmodule
